[design/crl_pkg.sv]
// ----------------------------------------------------------------------------
// crl_pkg
// Shared widths, request and result codes, controller states and the
// command and status bundles of the compacting record list.
// ----------------------------------------------------------------------------
package crl_pkg;

  // default depth of the record store
  localparam int CAPACITY_DEF = 512;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int CODE_W    = 31;
  localparam int PAY_W     = 24;
  localparam int COUNT_W   = 10;
  localparam int TOTAL_W   = 33;
  localparam int MEAN_W    = 24;
  localparam int DIV_CNT_W = $clog2(TOTAL_W);

  // request codes; any other code is a report
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DIV_LOAD,
    S_DIV_RUN
  } state_t;

  // one stored record
  typedef struct packed {
    logic [CODE_W-1:0] key;
    logic [PAY_W-1:0]  pay;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    app_write;
    logic    pos_clr;
    logic    rd_srch;
    logic    rd_shift;
    logic    match_sub;
    logic    shift_write;
    logic    pos_inc;
    logic    dec_count;
    logic    status_set;
    status_t status_code;
    logic    div_start;
    logic    result_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              key_match;
    logic              pos_last;
    logic              pos_next_last;
    logic              div_done;
  } sts_t;

endpackage

[design/crl_div.sv]
// ----------------------------------------------------------------------------
// crl_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crl_div #(
  parameter int CW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [crl_pkg::TOTAL_W-1:0] dividend,
  input  logic [CW-1:0]              divisor,
  output logic                       done,
  output logic [crl_pkg::TOTAL_W-1:0] quot
);

  localparam int TW = crl_pkg::TOTAL_W;

  logic [TW-1:0]                 quo_r, quo_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [crl_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [CW:0]                   trial;
  logic                          ge;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, quo_r[TW-1]};
    ge       = (trial >= {1'b0, divisor});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = crl_pkg::DIV_CNT_W'(TW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[TW-2:0], ge};
      rem_nxt = ge ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
      cnt_nxt = cnt_r - crl_pkg::DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // iteration registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

  // the done pulse closes a run
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("divider done while still running");

endmodule

[design/crl_dp.sv]
// ----------------------------------------------------------------------------
// crl_dp
// Datapath: record memory, count and total, search pointer, divider and
// result registers.
// ----------------------------------------------------------------------------
module crl_dp #(
  parameter int CAPACITY = crl_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [crl_pkg::FUNC_W-1:0]   in_func,
  input  logic [crl_pkg::CODE_W-1:0]   in_code,
  input  logic [crl_pkg::PAY_W-1:0]    in_salary_cents,
  input  crl_pkg::cmd_t                cmd,
  output crl_pkg::sts_t                sts,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [crl_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [crl_pkg::TOTAL_W-1:0]  out_salary_total,
  output logic [crl_pkg::MEAN_W-1:0]   out_salary_mean
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = crl_pkg::TOTAL_W;
  localparam int MW = crl_pkg::MEAN_W;

  // record memory
  crl_pkg::rec_t mem [CAPACITY];
  crl_pkg::rec_t rdata_r;

  // latched request
  logic [crl_pkg::FUNC_W-1:0] func_r;
  logic [crl_pkg::CODE_W-1:0] code_r;
  logic [crl_pkg::PAY_W-1:0]  pay_r;

  // list state
  logic [CW-1:0]      count_r, count_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  crl_pkg::status_t   stat_r;

  // result registers
  logic                       out_valid_r;
  crl_pkg::status_t           out_status_r;
  logic [crl_pkg::COUNT_W-1:0] out_count_r;
  logic [TW-1:0]              out_total_r;
  logic [MW-1:0]              out_mean_r;

  logic [AW-1:0]  raddr;
  logic           rd_en;
  logic           wr_en;
  logic [AW-1:0]  waddr;
  crl_pkg::rec_t  wdata;
  logic           div_done;
  logic [TW-1:0]  quot;
  logic [MW-1:0]  mean;
  logic [CW:0]    pos_p1;
  logic [CW:0]    pos_p2;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r <= in_func;
      code_r <= in_code;
      pay_r  <= in_salary_cents;
    end
  end

  // memory port selection
  always_comb begin
    rd_en = cmd.rd_srch || cmd.rd_shift;
    raddr = cmd.rd_shift ? AW'(pos_r + AW'(1)) : pos_r;
    wr_en = cmd.app_write || cmd.shift_write;
    waddr = cmd.app_write ? count_r[AW-1:0] : pos_r;
    wdata = cmd.app_write ? crl_pkg::rec_t'({code_r, pay_r}) : rdata_r;
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // count, total and pointer updates
  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    if (cmd.app_write) begin
      count_nxt = count_r + CW'(1);
      total_nxt = total_r + TW'(pay_r);
    end
    if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.match_sub) begin
      total_nxt = total_r - TW'(rdata_r.pay);
    end
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end else if (cmd.pos_inc || cmd.shift_write) begin
      pos_nxt = pos_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      pos_r   <= '0;
      stat_r  <= crl_pkg::ST_OK;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      if (cmd.status_set) begin
        stat_r <= cmd.status_code;
      end
    end
  end

  // status toward the controller
  always_comb begin
    pos_p1            = (CW + 1)'(pos_r) + (CW + 1)'(1);
    pos_p2            = (CW + 1)'(pos_r) + (CW + 1)'(2);
    sts.func          = func_r;
    sts.full          = (count_r == CW'(CAPACITY));
    sts.empty         = (count_r == '0);
    sts.key_match     = (rdata_r.key == code_r);
    sts.pos_last      = (pos_p1 >= (CW + 1)'(count_r));
    sts.pos_next_last = (pos_p2 >= (CW + 1)'(count_r));
    sts.div_done      = div_done;
  end

  // mean of the held salaries
  crl_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (total_r),
    .divisor  (count_r),
    .done     (div_done),
    .quot     (quot)
  );

  // saturate the quotient, zero for an empty list
  always_comb begin
    if (count_r == '0) begin
      mean = '0;
    end else if (quot[TW-1:MW] != '0) begin
      mean = '1;
    end else begin
      mean = quot[MW-1:0];
    end
  end

  // result registers and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.result_load;
    end
    if (cmd.result_load) begin
      out_status_r <= stat_r;
      out_count_r  <= crl_pkg::COUNT_W'(count_r);
      out_total_r  <= total_r;
      out_mean_r   <= mean;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_salary_total = out_total_r;
  assign out_salary_mean  = out_mean_r;

  // list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  // an append grows the list by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_write |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow the list");

  // an empty report carries zero total and mean
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == crl_pkg::ST_EMPTY)
      |-> (out_total_r == '0 && out_mean_r == '0))
    else $error("empty list reported nonzero totals");

endmodule

[design/crl_ctrl.sv]
// ----------------------------------------------------------------------------
// crl_ctrl
// Controller: decodes a request, for a delete steps the search and the shift
// through the record memory, then runs the divider and strobes the result.
// ----------------------------------------------------------------------------
module crl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  crl_pkg::sts_t sts,
  output crl_pkg::cmd_t cmd,
  output logic          busy
);

  crl_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.status_code = crl_pkg::ST_OK;
    unique case (state_r)
      crl_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = crl_pkg::S_DECODE;
        end
      end
      crl_pkg::S_DECODE: begin
        cmd.status_set = 1'b1;
        priority if (sts.func == crl_pkg::FN_APPEND) begin
          if (sts.full) begin
            cmd.status_code = crl_pkg::ST_FULL;
          end else begin
            cmd.app_write   = 1'b1;
          end
          state_nxt = crl_pkg::S_DIV_LOAD;
        end else if (sts.func == crl_pkg::FN_DELETE) begin
          if (sts.empty) begin
            cmd.status_code = crl_pkg::ST_MISSING;
            state_nxt       = crl_pkg::S_DIV_LOAD;
          end else begin
            cmd.status_set  = 1'b0;
            cmd.pos_clr     = 1'b1;
            state_nxt       = crl_pkg::S_SRCH_RD;
          end
        end else begin
          cmd.status_code = sts.empty ? crl_pkg::ST_EMPTY : crl_pkg::ST_OK;
          state_nxt       = crl_pkg::S_DIV_LOAD;
        end
      end
      crl_pkg::S_SRCH_RD: begin
        cmd.rd_srch = 1'b1;
        state_nxt   = crl_pkg::S_SRCH_CMP;
      end
      crl_pkg::S_SRCH_CMP: begin
        if (sts.key_match) begin
          cmd.match_sub = 1'b1;
          if (sts.pos_last) begin
            cmd.dec_count  = 1'b1;
            cmd.status_set = 1'b1;
            state_nxt      = crl_pkg::S_DIV_LOAD;
          end else begin
            state_nxt      = crl_pkg::S_SH_RD;
          end
        end else begin
          cmd.pos_inc = 1'b1;
          if (sts.pos_last) begin
            cmd.status_set  = 1'b1;
            cmd.status_code = crl_pkg::ST_MISSING;
            state_nxt       = crl_pkg::S_DIV_LOAD;
          end else begin
            state_nxt       = crl_pkg::S_SRCH_RD;
          end
        end
      end
      crl_pkg::S_SH_RD: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = crl_pkg::S_SH_WR;
      end
      crl_pkg::S_SH_WR: begin
        cmd.shift_write = 1'b1;
        if (sts.pos_next_last) begin
          cmd.dec_count  = 1'b1;
          cmd.status_set = 1'b1;
          state_nxt      = crl_pkg::S_DIV_LOAD;
        end else begin
          state_nxt      = crl_pkg::S_SH_RD;
        end
      end
      crl_pkg::S_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = crl_pkg::S_DIV_RUN;
      end
      crl_pkg::S_DIV_RUN: begin
        if (sts.div_done) begin
          cmd.result_load = 1'b1;
          state_nxt       = crl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = crl_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != crl_pkg::S_IDLE);

  // every shift write follows its read
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crl_pkg::S_SH_WR) |-> ($past(state_r) == crl_pkg::S_SH_RD))
    else $error("shift write without preceding read");

  // the result strobe returns the controller to idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crl_pkg::S_DIV_RUN && sts.div_done) |=> (state_r == crl_pkg::S_IDLE))
    else $error("controller did not return to idle after result");

endmodule

[design/compacting_record_list.sv]
// ----------------------------------------------------------------------------
// compacting_record_list
// Packed list of code and salary records with append, delete and report.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with out_valid high, and the
// receiver must take it then since it cannot hold results off. Append and
// report pass from acceptance through decode and the divider to the strobe,
// the divider forming the mean one quotient bit per cycle. A delete adds a
// read and a compare state for each record examined by the search and a read
// and a write state for each record moved down afterwards, all through the
// single memory read and write port. The records examined and the records
// moved together make up the whole list, so a delete steps through every
// record whether or not the code is found. busy falls in the cycle the
// result is shown, so the next request can follow at once.
module compacting_record_list #(
  parameter int CAPACITY = crl_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [crl_pkg::FUNC_W-1:0]   in_func,
  input  logic [crl_pkg::CODE_W-1:0]   in_code,
  input  logic [crl_pkg::PAY_W-1:0]    in_salary_cents,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [crl_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [crl_pkg::TOTAL_W-1:0]  out_salary_total,
  output logic [crl_pkg::MEAN_W-1:0]   out_salary_mean
);

  crl_pkg::cmd_t cmd;
  crl_pkg::sts_t sts;

  // sequencing
  crl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and arithmetic
  crl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_code          (in_code),
    .in_salary_cents  (in_salary_cents),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_salary_total (out_salary_total),
    .out_salary_mean  (out_salary_mean)
  );

endmodule

[verif/record_list_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_list_checker
// Watches the request and result channels of the compacting record list,
// keeps its own copy of the record store, works out the answer to every
// accepted request and compares each result with the oldest answer waiting.
// ----------------------------------------------------------------------------
module record_list_checker #(
  parameter int CAP = crl_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [crl_pkg::FUNC_W-1:0]  in_func,
  input  logic [crl_pkg::CODE_W-1:0]  in_code,
  input  logic [crl_pkg::PAY_W-1:0]   in_salary_cents,
  input  logic                        out_valid,
  input  logic [1:0]                  out_status,
  input  logic [crl_pkg::COUNT_W-1:0] out_entry_count,
  input  logic [crl_pkg::TOTAL_W-1:0] out_salary_total,
  input  logic [crl_pkg::MEAN_W-1:0]  out_salary_mean,
  output int                          fail_cnt,
  output int                          pend_cnt,
  output int                          held_cnt
);

  typedef struct packed {
    crl_pkg::status_t            status;
    logic [crl_pkg::COUNT_W-1:0] count;
    logic [crl_pkg::TOTAL_W-1:0] total;
    logic [crl_pkg::MEAN_W-1:0]  mean;
  } answer_t;

  // shadow of the record store
  logic [crl_pkg::CODE_W-1:0]  key_mem [CAP];
  logic [crl_pkg::PAY_W-1:0]   pay_mem [CAP];
  int                          held;
  logic [crl_pkg::TOTAL_W-1:0] pay_sum;

  answer_t answer_q [$];

  // apply one request to the shadow store and form its answer
  function automatic answer_t apply_request(logic [crl_pkg::FUNC_W-1:0] fn,
                                            logic [crl_pkg::CODE_W-1:0] code,
                                            logic [crl_pkg::PAY_W-1:0]  pay);
    answer_t          ans;
    crl_pkg::status_t st;
    int               pos;
    logic [63:0]      quot;
    st = crl_pkg::ST_OK;
    if (fn == crl_pkg::FN_APPEND) begin
      if (held >= CAP) begin
        st = crl_pkg::ST_FULL;
      end else begin
        key_mem[held] = code;
        pay_mem[held] = pay;
        held++;
        pay_sum = pay_sum + crl_pkg::TOTAL_W'(pay);
      end
    end else if (fn == crl_pkg::FN_DELETE) begin
      pos = 0;
      while (pos < held && key_mem[pos] != code) pos++;
      if (pos >= held) begin
        st = crl_pkg::ST_MISSING;
      end else begin
        // drop the oldest match and close the gap
        pay_sum = pay_sum - crl_pkg::TOTAL_W'(pay_mem[pos]);
        while (pos + 1 < held) begin
          key_mem[pos] = key_mem[pos+1];
          pay_mem[pos] = pay_mem[pos+1];
          pos++;
        end
        held--;
      end
    end else if (held == 0) begin
      st = crl_pkg::ST_EMPTY;
    end
    // truncated mean, saturated to the field
    quot = '0;
    if (held != 0) begin
      quot = {31'b0, pay_sum} / 64'(held);
      if (quot > 64'hFF_FFFF) quot = 64'hFF_FFFF;
    end
    ans.status = st;
    ans.count  = crl_pkg::COUNT_W'(held);
    ans.total  = pay_sum;
    ans.mean   = quot[crl_pkg::MEAN_W-1:0];
    return ans;
  endfunction

  // results first, then the new request of the same edge
  always @(posedge clk) begin
    answer_t ans;
    if (!rst_n) begin
      held    = 0;
      pay_sum = '0;
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result st=%0d cnt=%0d tot=%0d mean=%0d",
                     $realtime, out_status, out_entry_count, out_salary_total,
                     out_salary_mean);
        end else begin
          ans = answer_q.pop_front();
          if (out_status !== ans.status || out_entry_count !== ans.count ||
              out_salary_total !== ans.total || out_salary_mean !== ans.mean) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp st/cnt/tot/mean %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, ans.status, ans.count, ans.total, ans.mean,
                       out_status, out_entry_count, out_salary_total, out_salary_mean);
          end
        end
      end
      if (start && !busy) answer_q.push_back(apply_request(in_func, in_code, in_salary_cents));
    end
    pend_cnt = answer_q.size();
    held_cnt = held;
  end

endmodule

[verif/compacting_record_list_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compacting_record_list_tb
// Drives append, delete and report requests into the record list: a directed
// run over the corner cases, then random traffic that fills the list to the
// brim and deletes from it, under three idle profiles. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module compacting_record_list_tb;

  localparam logic [crl_pkg::FUNC_W-1:0] FN_REPORT = 2'd2;
  localparam logic [crl_pkg::FUNC_W-1:0] FN_SPARE  = 2'd3;
  localparam int                         CAP       = crl_pkg::CAPACITY_DEF;
  localparam int                         LIMIT     = 8_000_000;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        start           = 1'b0;
  logic [crl_pkg::FUNC_W-1:0]  in_func         = '0;
  logic [crl_pkg::CODE_W-1:0]  in_code         = '0;
  logic [crl_pkg::PAY_W-1:0]   in_salary_cents = '0;
  logic                        busy;
  logic                        out_valid;
  logic [1:0]                  out_status;
  logic [crl_pkg::COUNT_W-1:0] out_entry_count;
  logic [crl_pkg::TOTAL_W-1:0] out_salary_total;
  logic [crl_pkg::MEAN_W-1:0]  out_salary_mean;

  int fail_cnt;
  int pend_cnt;
  int held_cnt;
  int idle_pct;
  int max_pay_pct;
  int cycles;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  compacting_record_list i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_code          (in_code),
    .in_salary_cents  (in_salary_cents),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_salary_total (out_salary_total),
    .out_salary_mean  (out_salary_mean)
  );

  record_list_checker #(.CAP(CAP)) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_code          (in_code),
    .in_salary_cents  (in_salary_cents),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_salary_total (out_salary_total),
    .out_salary_mean  (out_salary_mean),
    .fail_cnt         (fail_cnt),
    .pend_cnt         (pend_cnt),
    .held_cnt         (held_cnt)
  );

  // mostly a small pool so deletes hit and duplicates pile up
  function automatic logic [crl_pkg::CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return crl_pkg::CODE_W'($urandom_range(0, 47));
    if (r < 90) return {crl_pkg::CODE_W{1'b1}} - crl_pkg::CODE_W'($urandom_range(0, 3));
    return crl_pkg::CODE_W'($urandom);
  endfunction

  function automatic logic [crl_pkg::PAY_W-1:0] pick_pay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 10 + max_pay_pct) return {crl_pkg::PAY_W{1'b1}};
    return crl_pkg::PAY_W'($urandom);
  endfunction

  // one request, held until the block takes it; returns on a falling edge
  task automatic send_req(logic [crl_pkg::FUNC_W-1:0] fn, logic [crl_pkg::CODE_W-1:0] code,
                          logic [crl_pkg::PAY_W-1:0] pay);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_func         <= fn;
    in_code         <= code;
    in_salary_cents <= pay;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic rand_req(int app_pct, int del_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < app_pct)
      send_req(crl_pkg::FN_APPEND, pick_code(), pick_pay());
    else if (r < app_pct + del_pct)
      send_req(crl_pkg::FN_DELETE, pick_code(), crl_pkg::PAY_W'($urandom));
    else
      send_req(crl_pkg::FUNC_W'($urandom_range(FN_REPORT, FN_SPARE)),
               crl_pkg::CODE_W'($urandom), crl_pkg::PAY_W'($urandom));
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pend_cnt != 0) @(negedge clk);
  endtask

  // run limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("compacting_record_list_tb NOT OK");
    $finish;
  end

  initial begin
    idle_pct    = 0;
    max_pay_pct = 10;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners: empty list, extremes, duplicates, spare selector
    send_req(FN_REPORT, '0, '0);
    send_req(FN_SPARE, {crl_pkg::CODE_W{1'b1}}, {crl_pkg::PAY_W{1'b1}});
    send_req(crl_pkg::FN_DELETE, '0, '0);
    send_req(crl_pkg::FN_APPEND, '0, '0);
    send_req(crl_pkg::FN_APPEND, {crl_pkg::CODE_W{1'b1}}, {crl_pkg::PAY_W{1'b1}});
    send_req(crl_pkg::FN_APPEND, 31'd5, 24'd100);
    send_req(crl_pkg::FN_APPEND, 31'd5, 24'd200);
    send_req(crl_pkg::FN_APPEND, 31'h2AAA_AAAA, 24'hAA_AAAA);
    send_req(crl_pkg::FN_APPEND, 31'h5555_5555, 24'h55_5555);
    send_req(FN_REPORT, '0, '0);
    send_req(crl_pkg::FN_DELETE, 31'd5, '0);
    send_req(FN_SPARE, '0, '0);
    send_req(crl_pkg::FN_DELETE, 31'd5, {crl_pkg::PAY_W{1'b1}});
    send_req(crl_pkg::FN_DELETE, 31'd5, '0);
    send_req(crl_pkg::FN_DELETE, {crl_pkg::CODE_W{1'b1}}, '0);
    send_req(crl_pkg::FN_DELETE, 31'h5555_5555, '0);
    send_req(crl_pkg::FN_DELETE, '0, '0);
    send_req(crl_pkg::FN_DELETE, 31'h2AAA_AAAA, '0);
    send_req(FN_REPORT, '0, '0);
    send_req(crl_pkg::FN_APPEND, 31'd1, 24'd500);
    send_req(crl_pkg::FN_DELETE, 31'd1, '0);
    send_req(FN_REPORT, '0, '0);
    wait_idle();

    // mixed traffic on a short list, with occasional full drains
    idle_pct = 14;
    repeat (20) begin
      rand_req(45, 35);
      if ($urandom_range(0, 19) == 0) wait_idle();
    end
    wait_idle();

    // fill to capacity, then push against the full list
    idle_pct    = 55;
    max_pay_pct = 40;
    while (held_cnt < CAP) rand_req(98, 0);
    repeat (8) rand_req(100, 0);
    repeat (2) rand_req(0, 0);
    repeat (4) rand_req(0, 100);
    repeat (3) rand_req(100, 0);
    wait_idle();

    // back to back, delete heavy from a near-full list
    idle_pct    = 0;
    max_pay_pct = 10;
    repeat (20) rand_req(20, 60);

    // drain and settle
    start <= 1'b0;
    @(negedge clk);
    while (pend_cnt != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_cnt == 0 && pend_cnt == 0)
      $display("compacting_record_list_tb OK");
    else
      $display("compacting_record_list_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
design/crl_pkg.sv
design/crl_div.sv
design/crl_dp.sv
design/crl_ctrl.sv
design/compacting_record_list.sv
verif/record_list_checker.sv
verif/compacting_record_list_tb.sv
